### sv/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/tcq_pkg.sv
// Shared types and codes of the two-class queue with timeouts.
`default_nettype none

package tcq_pkg;

  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_SERVE  = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_EMPTY   = 2'd2,
    STAT_BAD_POS = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_PUT,
    S_RM,
    S_TICK,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

### sv/two_class_queue_with_timeouts.sv
// Top level of the two-class queue with per-entry patience timeouts.
//
// Commands arrive as beats on the in_ channel (valid/ready); every command
// gives exactly one result beat on the out_ channel (valid/ready).
// Entries live in one RAM of QUEUE_DEPTH words; commands that move entries
// stream through the RAM one slot per cycle, reading ahead of the write
// pointer so a slot is always read before it is overwritten.
// Errors, a regular add, a priority add into an empty queue and a tick of an
// empty queue go straight to the result step. A priority add walks from the
// tail, moves regular entries back one slot each and then writes the new
// entry; a serve or a remove moves every entry behind the position one slot
// forward; a tick walks every entry. The RAM has a single read port, and one
// command is in work at a time, so a new command is taken only once the last
// has reached the result step.
// in_ready is high only while no command is in work. A finished result waits
// in the output register, and the next command is taken meanwhile; a stalled
// receiver only holds back the step that would overwrite that register.
// Reset empties the queue at once; the RAM needs no clearing pass, since
// only slots below the entry count are ever read.
`default_nettype none

module two_class_queue_with_timeouts #(
  parameter int QUEUE_DEPTH   = 16,
  parameter int PATIENCE_BITS = 8
) (
  input  wire logic       clk,
  input  wire logic       rst_n,

  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_cmd,
  input  wire logic       in_new_priority,
  input  wire logic [7:0] in_new_patience,
  input  wire logic [2:0] in_new_persons,
  input  wire logic [4:0] in_position,

  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_out_valid,
  output logic            out_out_priority,
  output logic [7:0]      out_out_patience,
  output logic [2:0]      out_out_persons,
  output logic [4:0]      out_expired_count,
  output logic [4:0]      out_occupancy,
  output logic [1:0]      out_status
);

  localparam int IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int ENT_W  = PATIENCE_BITS + 4;
  localparam int PRIO_B = ENT_W - 1;
  localparam int PAT_HI = ENT_W - 2;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  // Control state.
  tcq_pkg::state_t    state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               rd_live_r, rd_live_nxt;
  logic               pend_r, pend_nxt;
  logic               ovld_r, ovld_nxt;

  // Working payload.
  logic [ENT_W-1:0]   ent_r, ent_nxt;
  logic [IDX_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0]   p_r, p_nxt;
  logic [CNT_W-1:0]   keep_r, keep_nxt;
  logic [CNT_W-1:0]   exp_r, exp_nxt;
  logic               first_r, first_nxt;
  logic               res_hit_r, res_hit_nxt;
  logic [ENT_W-1:0]   res_ent_r, res_ent_nxt;
  tcq_pkg::status_t   res_status_r, res_status_nxt;

  // Output register.
  logic               o_hit_r, o_hit_nxt;
  logic [ENT_W-1:0]   o_ent_r, o_ent_nxt;
  logic [4:0]         o_exp_r, o_exp_nxt;
  logic [4:0]         o_occ_r, o_occ_nxt;
  tcq_pkg::status_t   o_status_r, o_status_nxt;

  // RAM port.
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENT_W-1:0]   ram_wdata;
  logic               ram_re;
  logic [ENT_W-1:0]   ram_rdata;

  logic               accept;
  logic [ENT_W-1:0]   in_ent;
  logic [CNT_W-1:0]   cnt_m1;
  logic [4:0]         pos_m1;
  logic               bad_pos;
  logic               last;
  logic [PATIENCE_BITS-1:0] rd_pat;
  logic               rd_keep;
  logic               out_free;

  assign accept   = in_valid && in_ready;
  assign in_ent   = {in_new_priority, PATIENCE_BITS'(in_new_patience), in_new_persons};
  assign cnt_m1   = count_r - 1'b1;
  assign pos_m1   = in_position - 5'd1;
  assign bad_pos  = (in_position == 5'd0) || (32'(in_position) > 32'(count_r));
  assign last     = (CNT_W'(p_r) == cnt_m1);
  assign rd_pat   = ram_rdata[PAT_HI:3];
  // The decrement saturates at zero, so anything at one or below expires.
  assign rd_keep  = (rd_pat > PATIENCE_BITS'(1));
  assign out_free = !ovld_r || out_ready;

  tcq_ram #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_idx_r),
    .rdata (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tcq_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = tcq_pkg::S_DONE;
          case (tcq_pkg::cmd_t'(in_cmd))
            tcq_pkg::CMD_ADD: begin
              if (count_r != FULL_CNT && in_new_priority && count_r != '0) begin
                state_nxt = tcq_pkg::S_INS;
              end
            end
            tcq_pkg::CMD_SERVE: begin
              if (count_r != '0) begin
                state_nxt = tcq_pkg::S_RM;
              end
            end
            tcq_pkg::CMD_REMOVE: begin
              if (!bad_pos) begin
                state_nxt = tcq_pkg::S_RM;
              end
            end
            tcq_pkg::CMD_TICK: begin
              if (count_r != '0) begin
                state_nxt = tcq_pkg::S_TICK;
              end
            end
            default: state_nxt = tcq_pkg::S_DONE;
          endcase
        end
      end
      tcq_pkg::S_INS: begin
        if (pend_r) begin
          if (ram_rdata[PRIO_B]) begin
            state_nxt = tcq_pkg::S_DONE;
          end else if (p_r == '0) begin
            state_nxt = tcq_pkg::S_PUT;
          end
        end
      end
      tcq_pkg::S_PUT: state_nxt = tcq_pkg::S_DONE;
      tcq_pkg::S_RM, tcq_pkg::S_TICK: begin
        if (pend_r && last) begin
          state_nxt = tcq_pkg::S_DONE;
        end
      end
      tcq_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = tcq_pkg::S_IDLE;
        end
      end
      default: state_nxt = tcq_pkg::S_IDLE;
    endcase
  end

  // Datapath, RAM access and handshake outputs.
  always_comb begin
    count_nxt      = count_r;
    rd_live_nxt    = rd_live_r;
    pend_nxt       = 1'b0;
    ovld_nxt       = ovld_r;
    ent_nxt        = ent_r;
    rd_idx_nxt     = rd_idx_r;
    p_nxt          = p_r;
    keep_nxt       = keep_r;
    exp_nxt        = exp_r;
    first_nxt      = first_r;
    res_hit_nxt    = res_hit_r;
    res_ent_nxt    = res_ent_r;
    res_status_nxt = res_status_r;
    o_hit_nxt      = o_hit_r;
    o_ent_nxt      = o_ent_r;
    o_exp_nxt      = o_exp_r;
    o_occ_nxt      = o_occ_r;
    o_status_nxt   = o_status_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_re         = 1'b0;
    in_ready       = (state_r == tcq_pkg::S_IDLE);

    if (ovld_r && out_ready) begin
      ovld_nxt = 1'b0;
    end

    case (state_r)
      tcq_pkg::S_IDLE: begin
        if (accept) begin
          res_hit_nxt    = 1'b0;
          res_status_nxt = tcq_pkg::STAT_OK;
          exp_nxt        = '0;
          keep_nxt       = '0;
          first_nxt      = 1'b1;
          rd_live_nxt    = 1'b1;
          ent_nxt        = in_ent;
          case (tcq_pkg::cmd_t'(in_cmd))
            tcq_pkg::CMD_ADD: begin
              if (count_r == FULL_CNT) begin
                res_status_nxt = tcq_pkg::STAT_FULL;
              end else if (!in_new_priority || count_r == '0) begin
                // Tail append, or a priority add into an empty queue.
                ram_we    = 1'b1;
                ram_waddr = IDX_W'(count_r);
                ram_wdata = in_ent;
                count_nxt = count_r + 1'b1;
              end else begin
                rd_idx_nxt = IDX_W'(cnt_m1);
                p_nxt      = IDX_W'(cnt_m1);
              end
            end
            tcq_pkg::CMD_SERVE: begin
              if (count_r == '0) begin
                res_status_nxt = tcq_pkg::STAT_EMPTY;
              end else begin
                rd_idx_nxt = '0;
                p_nxt      = '0;
              end
            end
            tcq_pkg::CMD_REMOVE: begin
              if (bad_pos) begin
                res_status_nxt = tcq_pkg::STAT_BAD_POS;
              end else begin
                rd_idx_nxt = IDX_W'(pos_m1);
                p_nxt      = IDX_W'(pos_m1);
              end
            end
            tcq_pkg::CMD_TICK: begin
              rd_idx_nxt = '0;
              p_nxt      = '0;
            end
            default: res_status_nxt = tcq_pkg::STAT_OK;
          endcase
        end
      end

      tcq_pkg::S_INS: begin
        // Walk from the tail toward the head, moving regular entries back.
        ram_re      = rd_live_r;
        pend_nxt    = rd_live_r;
        rd_idx_nxt  = rd_idx_r - 1'b1;
        rd_live_nxt = rd_live_r && (rd_idx_r != '0);
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = p_r + 1'b1;
          if (ram_rdata[PRIO_B]) begin
            ram_wdata = ent_r;
            count_nxt = count_r + 1'b1;
          end else begin
            ram_wdata = ram_rdata;
            p_nxt     = p_r - 1'b1;
          end
        end
      end

      tcq_pkg::S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = ent_r;
        count_nxt = count_r + 1'b1;
      end

      tcq_pkg::S_RM: begin
        // The first beat of read data is the removed entry; the rest move up.
        ram_re      = rd_live_r;
        pend_nxt    = rd_live_r;
        rd_idx_nxt  = rd_idx_r + 1'b1;
        rd_live_nxt = rd_live_r && ((CNT_W'(rd_idx_r) + 1'b1) < count_r);
        if (pend_r) begin
          p_nxt = p_r + 1'b1;
          if (first_r) begin
            first_nxt   = 1'b0;
            res_hit_nxt = 1'b1;
            res_ent_nxt = ram_rdata;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = p_r - 1'b1;
            ram_wdata = ram_rdata;
          end
          if (last) begin
            count_nxt = cnt_m1;
          end
        end
      end

      tcq_pkg::S_TICK: begin
        ram_re      = rd_live_r;
        pend_nxt    = rd_live_r;
        rd_idx_nxt  = rd_idx_r + 1'b1;
        rd_live_nxt = rd_live_r && ((CNT_W'(rd_idx_r) + 1'b1) < count_r);
        if (pend_r) begin
          p_nxt = p_r + 1'b1;
          if (rd_keep) begin
            ram_we    = 1'b1;
            ram_waddr = IDX_W'(keep_r);
            ram_wdata = {ram_rdata[PRIO_B], rd_pat - 1'b1, ram_rdata[2:0]};
            keep_nxt  = keep_r + 1'b1;
          end else begin
            exp_nxt = exp_r + 1'b1;
          end
          if (last) begin
            count_nxt = keep_nxt;
          end
        end
      end

      tcq_pkg::S_DONE: begin
        if (out_free) begin
          ovld_nxt     = 1'b1;
          o_hit_nxt    = res_hit_r;
          o_ent_nxt    = res_hit_r ? res_ent_r : '0;
          o_exp_nxt    = 5'(exp_r);
          o_occ_nxt    = 5'(count_r);
          o_status_nxt = res_status_r;
        end
      end

      default: pend_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= tcq_pkg::S_IDLE;
      count_r   <= '0;
      rd_live_r <= 1'b0;
      pend_r    <= 1'b0;
      ovld_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      rd_live_r <= rd_live_nxt;
      pend_r    <= pend_nxt;
      ovld_r    <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r        <= ent_nxt;
    rd_idx_r     <= rd_idx_nxt;
    p_r          <= p_nxt;
    keep_r       <= keep_nxt;
    exp_r        <= exp_nxt;
    first_r      <= first_nxt;
    res_hit_r    <= res_hit_nxt;
    res_ent_r    <= res_ent_nxt;
    res_status_r <= res_status_nxt;
    o_hit_r      <= o_hit_nxt;
    o_ent_r      <= o_ent_nxt;
    o_exp_r      <= o_exp_nxt;
    o_occ_r      <= o_occ_nxt;
    o_status_r   <= o_status_nxt;
  end

  assign out_valid         = ovld_r;
  assign out_out_valid     = o_hit_r;
  assign out_out_priority  = o_ent_r[PRIO_B];
  assign out_out_patience  = 8'(o_ent_r[PAT_HI:3]);
  assign out_out_persons   = o_ent_r[2:0];
  assign out_expired_count = o_exp_r;
  assign out_occupancy     = o_occ_r;
  assign out_status        = o_status_r;

endmodule

`default_nettype wire

### sv/tcq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module tcq_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### sv/tcq_checker.sv
// Port-level checks of the two-class queue, bound to its top level.
`default_nettype none
`include "assert_macros.svh"

module tcq_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_out_valid,
  input wire logic       out_out_priority,
  input wire logic [7:0] out_out_patience,
  input wire logic [2:0] out_out_persons,
  input wire logic [4:0] out_expired_count,
  input wire logic [4:0] out_occupancy,
  input wire logic [1:0] out_status
);

  // A returned entry always comes with a clean status.
  `ASSERT_IMPLY(a_hit_ok, clk, rst_n, out_valid && out_out_valid, out_status == tcq_pkg::STAT_OK, "entry returned with error status")

  // A rejected command returns nothing and drops nothing.
  `ASSERT_IMPLY(a_err_empty, clk, rst_n, out_valid && out_status != tcq_pkg::STAT_OK, !out_out_valid && out_expired_count == 5'd0 && out_out_patience == 8'd0, "rejected command carries data")

  // A tick drops entries but never hands one back.
  `ASSERT_IMPLY(a_tick_no_hit, clk, rst_n, out_valid && out_expired_count != 5'd0, !out_out_valid, "tick returned an entry")

  // A stalled result beat holds.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_out_valid) && $stable(out_out_priority) && $stable(out_out_patience) && $stable(out_out_persons) && $stable(out_expired_count) && $stable(out_occupancy) && $stable(out_status), "stalled result changed")

endmodule

bind two_class_queue_with_timeouts tcq_checker u_tcq_checker (.*);

`default_nettype wire

### dv/two_class_queue_with_timeouts_tb.sv
// Self-checking testbench for the two-class queue with patience timeouts.
`default_nettype none

module two_class_queue_with_timeouts_tb;

  localparam int QDEPTH = 16;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic       pri;
    logic [7:0] pat;
    logic [2:0] pers;
  } entry_t;

  typedef struct packed {
    logic             valid;
    logic             pri;
    logic [7:0]       pat;
    logic [2:0]       pers;
    logic [4:0]       expired;
    logic [4:0]       occ;
    tcq_pkg::status_t status;
  } result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_cmd = tcq_pkg::CMD_TICK;
  logic       in_new_priority = 1'b0;
  logic [7:0] in_new_patience = 8'd0;
  logic [2:0] in_new_persons = 3'd0;
  logic [4:0] in_position = 5'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_out_valid;
  logic       out_out_priority;
  logic [7:0] out_out_patience;
  logic [2:0] out_out_persons;
  logic [4:0] out_expired_count;
  logic [4:0] out_occupancy;
  logic [1:0] out_status;

  // Predicted queue contents, head at index 0.
  entry_t  waiting_line [QDEPTH];
  int      waiting_count = 0;
  result_t expected_results [$];
  int      mismatches = 0;
  int      sender_idle_pct = 0;
  int      receiver_idle_pct = 0;

  two_class_queue_with_timeouts uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_new_priority  (in_new_priority),
    .in_new_patience  (in_new_patience),
    .in_new_persons   (in_new_persons),
    .in_position      (in_position),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_out_valid    (out_out_valid),
    .out_out_priority (out_out_priority),
    .out_out_patience (out_out_patience),
    .out_out_persons  (out_out_persons),
    .out_expired_count(out_expired_count),
    .out_occupancy    (out_occupancy),
    .out_status       (out_status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  // Removes the entry at zero-based index idx and closes the gap.
  function automatic result_t take_entry(int idx);
    result_t r;
    r = '0;
    r.valid = 1'b1;
    r.pri = waiting_line[idx].pri;
    r.pat = waiting_line[idx].pat;
    r.pers = waiting_line[idx].pers;
    for (int i = idx; i + 1 < waiting_count; i++) waiting_line[i] = waiting_line[i + 1];
    waiting_count--;
    return r;
  endfunction

  function automatic result_t predict_queue_step(tcq_pkg::cmd_t cmd, logic pri,
                                                 logic [7:0] pat, logic [2:0] pers,
                                                 logic [4:0] pos);
    result_t r;
    int at;
    int keep;
    int dropped;
    r = '0;
    r.status = tcq_pkg::STAT_OK;
    dropped = 0;
    case (cmd)
      tcq_pkg::CMD_ADD: begin
        if (waiting_count >= QDEPTH) begin
          r.status = tcq_pkg::STAT_FULL;
        end else begin
          at = waiting_count;
          if (pri) begin
            // A priority entry overtakes every regular entry behind the last priority one.
            while (at > 0 && !waiting_line[at - 1].pri) begin
              waiting_line[at] = waiting_line[at - 1];
              at--;
            end
          end
          waiting_line[at] = '{pri: pri, pat: pat, pers: pers};
          waiting_count++;
        end
      end
      tcq_pkg::CMD_SERVE: begin
        if (waiting_count == 0) r.status = tcq_pkg::STAT_EMPTY;
        else r = take_entry(0);
      end
      tcq_pkg::CMD_REMOVE: begin
        if (pos == 0 || pos > waiting_count) r.status = tcq_pkg::STAT_BAD_POS;
        else r = take_entry(int'(pos) - 1);
      end
      default: begin
        keep = 0;
        for (int i = 0; i < waiting_count; i++) begin
          if (waiting_line[i].pat != 0) waiting_line[i].pat--;
        end
        for (int i = 0; i < waiting_count; i++) begin
          if (waiting_line[i].pat == 0) begin
            dropped++;
          end else begin
            waiting_line[keep] = waiting_line[i];
            keep++;
          end
        end
        waiting_count = keep;
      end
    endcase
    r.expired = dropped[4:0];
    r.occ = waiting_count[4:0];
    return r;
  endfunction

  // Entered and left right after a rising edge.
  task automatic send_command(tcq_pkg::cmd_t cmd, logic pri, logic [7:0] pat,
                              logic [2:0] pers, logic [4:0] pos);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_new_priority <= pri;
    in_new_patience <= pat;
    in_new_persons <= pers;
    in_position <= pos;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(predict_queue_step(cmd, pri, pat, pers, pos));
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{valid: out_out_valid, pri: out_out_priority, pat: out_out_patience,
              pers: out_out_persons, expired: out_expired_count, occ: out_occupancy,
              status: tcq_pkg::status_t'(out_status)};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result beat: valid=%0d pri=%0d pat=%0d pers=%0d exp=%0d",
                   got.valid, got.pri, got.pat, got.pers, got.expired,
                   "  occ=%0d st=%0d", got.occ, got.status);
      end else begin
        want = expected_results.pop_front();
        if (got.valid !== want.valid || got.pri !== want.pri || got.pat !== want.pat ||
            got.pers !== want.pers || got.expired !== want.expired ||
            got.occ !== want.occ || got.status !== want.status) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("result mismatch at %0t", $realtime);
            $display("  expected: valid=%0d pri=%0d pat=%0d pers=%0d exp=%0d occ=%0d st=%0d",
                     want.valid, want.pri, want.pat, want.pers, want.expired, want.occ,
                     want.status);
            $display("  actual:   valid=%0d pri=%0d pat=%0d pers=%0d exp=%0d occ=%0d st=%0d",
                     got.valid, got.pri, got.pat, got.pers, got.expired, got.occ,
                     got.status);
          end
        end
      end
    end
  end

  task automatic test_empty_queue();
    send_command(tcq_pkg::CMD_SERVE, 1'b0, 8'd0, 3'd0, 5'd0);
    send_command(tcq_pkg::CMD_REMOVE, 1'b1, 8'hff, 3'd7, 5'd0);
    send_command(tcq_pkg::CMD_REMOVE, 1'b0, 8'd0, 3'd0, 5'd1);
    send_command(tcq_pkg::CMD_TICK, 1'b0, 8'd0, 3'd0, 5'd0);
  endtask

  // Fills the queue with mixed classes, then hits the full and bounds cases and expiry.
  task automatic test_full_queue();
    logic [7:0] pat;
    for (int i = 0; i < QDEPTH; i++) begin
      pat = (i == 0) ? 8'd0 : (i == 1) ? 8'hff : (i == 2) ? 8'd1 : 8'(i + 2);
      send_command(tcq_pkg::CMD_ADD, (i % 3) == 1, pat, 3'(i % 8), 5'(i));
    end
    send_command(tcq_pkg::CMD_ADD, 1'b1, 8'hff, 3'd7, 5'd31);
    send_command(tcq_pkg::CMD_REMOVE, 1'b0, 8'd0, 3'd0, 5'd17);
    send_command(tcq_pkg::CMD_REMOVE, 1'b0, 8'd0, 3'd0, 5'd16);
    send_command(tcq_pkg::CMD_TICK, 1'b1, 8'hff, 3'd7, 5'd31);
    send_command(tcq_pkg::CMD_SERVE, 1'b0, 8'd0, 3'd0, 5'd0);
  endtask

  // Alternates fill-heavy and drain-heavy stretches so both full and empty are reached.
  task automatic test_random_mix(int count);
    int roll;
    int add_pct;
    tcq_pkg::cmd_t cmd;
    logic [7:0] pat;
    logic [4:0] pos;
    for (int n = 0; n < count; n++) begin
      add_pct = ((n / 50) % 2 == 0) ? 70 : 35;
      roll = $urandom_range(99);
      if (roll < add_pct) cmd = tcq_pkg::CMD_ADD;
      else if (roll < add_pct + (100 - add_pct) / 3) cmd = tcq_pkg::CMD_SERVE;
      else if (roll < add_pct + 2 * (100 - add_pct) / 3) cmd = tcq_pkg::CMD_REMOVE;
      else cmd = tcq_pkg::CMD_TICK;
      pat = ($urandom_range(99) < 70) ? 8'($urandom_range(0, 6))
                                      : 8'($urandom_range(0, 255));
      if (cmd == tcq_pkg::CMD_REMOVE && waiting_count > 0 && $urandom_range(99) < 80)
        pos = 5'($urandom_range(1, waiting_count));
      else
        pos = 5'($urandom_range(0, 31));
      send_command(cmd, 1'($urandom_range(1)), pat, 3'($urandom_range(0, 7)), pos);
    end
  endtask

  initial begin
    #5000000;
    $display("two_class_queue_with_timeouts_tb failed");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    sender_idle_pct = 13;
    receiver_idle_pct = 80;
    test_empty_queue();
    test_full_queue();
    test_random_mix(290);
    wait_for_drain();
    sender_idle_pct = 80;
    receiver_idle_pct = 13;
    test_random_mix(290);
    wait_for_drain();
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    test_random_mix(300);
    wait_for_drain();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("two_class_queue_with_timeouts_tb passed");
    end else begin
      $display("two_class_queue_with_timeouts_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
